### src/nbfm_pkg.sv
`timescale 1ns / 1ps
package nbfm_pkg;
    localparam int TableDepth = 256;
    localparam int JointCount = 7;
    localparam int AddrW = $clog2(TableDepth);
    localparam int CountW = $clog2(TableDepth + 1);
    localparam int EntryW = 16 * (JointCount + 3);
    localparam logic [14:0] ThresholdReset = 15'd640;

    localparam logic [2:0] ActJoint  = 3'd0;
    localparam logic [2:0] ActForce  = 3'd1;
    localparam logic [2:0] ActCheck  = 3'd2;
    localparam logic [2:0] ActStart  = 3'd3;
    localparam logic [2:0] ActFinish = 3'd4;

    localparam logic [1:0] StatOk    = 2'd0;
    localparam logic [1:0] StatEmpty = 2'd1;
    localparam logic [1:0] StatFull  = 2'd2;

    typedef struct packed {
        logic [2:0]  action;
        logic signed [15:0] joint_pos_0;
        logic signed [15:0] joint_pos_1;
        logic signed [15:0] joint_pos_2;
        logic signed [15:0] joint_pos_3;
        logic signed [15:0] joint_pos_4;
        logic signed [15:0] joint_pos_5;
        logic signed [15:0] joint_pos_6;
        logic signed [15:0] force_x;
        logic signed [15:0] force_y;
        logic signed [15:0] force_z;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic        safe;
        logic        stop_request;
        logic        restored;
        logic [7:0]  nearest_index;
        logic [33:0] delta_square;
        logic [8:0]  sample_count;
        logic        recording;
    } t_out_item;
endpackage

### src/nbfm_if.sv
`timescale 1ns / 1ps
interface nbfm_in_if import nbfm_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface nbfm_out_if import nbfm_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

### src/nbfm_ram.sv
`timescale 1ns / 1ps
module nbfm_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### src/nearest_baseline_force_monitor.sv
`timescale 1ns / 1ps
// Nearest-baseline force monitor. One transaction in gives one transaction out.
// Joint updates, force samples and recording commands pass from IDLE through
// EXEC to OUT. An applicable check tick walks the stored baseline table
// through a single squared-difference unit that handles one coordinate per
// cycle. Each entry takes a read step (RD) and then one accumulate step (ACC)
// for each of the seven joint coordinates. The nearest entry is then read again
// (FRD) and its three force coordinates are summed (FACC) before the result
// goes out (OUT). The block is not ready while a transaction is in work or
// its result waits. Baseline entries live in one RAM with a registered read;
// only entries below the sample count are used by a search.
module nearest_baseline_force_monitor
    import nbfm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        cfg_we,
    input  logic [14:0] cfg_wdata,
    nbfm_in_if.sink     in_ch,
    nbfm_out_if.source  out_ch
);
    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_EXEC  = 7'b0000010,
        S_RD    = 7'b0000100,
        S_ACC   = 7'b0001000,
        S_FRD   = 7'b0010000,
        S_FACC  = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic [14:0] r_thr;
    logic signed [15:0] r_joint [JointCount];
    logic signed [15:0] r_force [3];
    logic r_jseen, r_fseen, r_rec, r_loaded, r_stop;
    logic [CountW-1:0] r_count;
    t_in_item r_item;
    t_out_item r_out;

    // search bookkeeping
    logic [AddrW-1:0] r_idx, r_best_idx;
    logic [CountW-1:0] r_walk;
    logic [3:0] r_coord;
    logic [35:0] r_dist, r_best;
    logic r_have;
    logic [EntryW-1:0] rd_data;
    logic [AddrW-1:0] rd_addr;
    logic we;
    logic [EntryW-1:0] wdata;

    assign in_ch.ready = (r_state == S_IDLE);
    assign out_ch.valid = (r_state == S_OUT);
    assign out_ch.payload = r_out;

    always_comb begin
        wdata = '0;
        for (int j = 0; j < JointCount; j++) begin
            wdata[16*j +: 16] = r_joint[j];
        end
        for (int j = 0; j < 3; j++) begin
            wdata[16*(JointCount+j) +: 16] = r_force[j];
        end
    end

    assign we = (r_state == S_EXEC) && (r_item.action == ActForce) && r_rec && r_jseen
                && (r_count < CountW'(TableDepth));

    nbfm_ram #(.Width(EntryW), .Depth(TableDepth)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(r_count[AddrW-1:0]),
        .i_wdata(wdata),
        .i_raddr(rd_addr),
        .o_rdata(rd_data)
    );
    assign rd_addr = (r_state == S_FRD || r_state == S_FACC) ? r_best_idx : r_idx;

    // shared squared-difference unit: one coordinate per cycle
    logic signed [15:0] op_a, op_b;
    logic signed [16:0] diff;
    logic [16:0] mag;
    logic [33:0] sq;
    always_comb begin
        if (r_state == S_FACC) begin
            op_a = r_force[r_coord[1:0] < 2'd3 ? r_coord[1:0] : 2'd0];
            op_b = rd_data[16*(JointCount + 32'(r_coord[1:0] < 2'd3 ? r_coord[1:0] : 2'd0))
                   +: 16];
        end else begin
            op_a = r_joint[r_coord[2:0] < 3'(JointCount) ? r_coord[2:0] : 3'd0];
            op_b = rd_data[16*(r_coord[2:0] < 3'(JointCount) ? 32'(r_coord[2:0]) : 0) +: 16];
        end
        diff = 17'(op_a) - 17'(op_b);
        mag = diff[16] ? 17'(-diff) : diff;
        sq = 34'(mag) * 34'(mag);
    end

    logic [29:0] thr_sq;
    assign thr_sq = 30'(r_thr) * 30'(r_thr);

    // check applies only with a loaded table and both inputs seen
    logic chk_ok;
    assign chk_ok = r_loaded && r_fseen && r_jseen && (r_count != '0);

    logic [35:0] facc_sum;
    assign facc_sum = r_dist + 36'(sq);

    // next result: build it in EXEC, finish it on the last force coordinate
    t_out_item n_out;
    always_comb begin
        n_out = r_out;
        if (r_state == S_EXEC) begin
            n_out = '{status: StatOk, safe: 1'b1, stop_request: 1'b0,
                      restored: 1'b0, nearest_index: '0, delta_square: '0,
                      sample_count: 9'(r_count), recording: r_rec};
            case (r_item.action)
                ActForce: begin
                    if (r_rec && r_jseen) begin
                        if (r_count < CountW'(TableDepth)) begin
                            n_out.sample_count = 9'(r_count + 1'b1);
                        end else begin
                            n_out.status = StatFull;
                        end
                    end
                end
                ActCheck: begin
                    // not applicable: safe, episode may end
                    if (!chk_ok && r_stop) n_out.restored = 1'b1;
                end
                ActStart: begin
                    n_out.sample_count = '0;
                    n_out.recording = 1'b1;
                end
                ActFinish: begin
                    n_out.recording = 1'b0;
                    if (r_count == 0) n_out.status = StatEmpty;
                end
                default: ;
            endcase
        end else if (r_state == S_FACC && r_coord == 4'd2) begin
            n_out.delta_square = 34'(facc_sum);
            n_out.nearest_index = 8'(r_best_idx);
            if (facc_sum > 36'(thr_sq)) begin
                n_out.safe = 1'b0;
                if (!r_stop) n_out.stop_request = 1'b1;
            end else if (r_stop) begin
                n_out.restored = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_thr <= ThresholdReset;
            r_jseen <= 1'b0;
            r_fseen <= 1'b0;
            r_rec <= 1'b0;
            r_loaded <= 1'b0;
            r_stop <= 1'b0;
            r_count <= '0;
            for (int j = 0; j < JointCount; j++) r_joint[j] <= '0;
            for (int j = 0; j < 3; j++) r_force[j] <= '0;
        end else begin
            if (cfg_we) begin
                r_thr <= cfg_wdata;
            end
            r_state <= n_state;
            r_out <= n_out;
            case (r_state)
                S_IDLE: begin
                    if (in_ch.valid) begin
                        r_item <= in_ch.payload;
                    end
                end
                S_EXEC: begin
                    r_idx <= '0;
                    r_walk <= '0;
                    r_coord <= '0;
                    r_dist <= '0;
                    r_have <= 1'b0;
                    r_best_idx <= '0;
                    case (r_item.action)
                        ActJoint: begin
                            r_joint[0] <= r_item.joint_pos_0;
                            if (JointCount > 1) r_joint[1 % JointCount] <= r_item.joint_pos_1;
                            if (JointCount > 2) r_joint[2 % JointCount] <= r_item.joint_pos_2;
                            if (JointCount > 3) r_joint[3 % JointCount] <= r_item.joint_pos_3;
                            if (JointCount > 4) r_joint[4 % JointCount] <= r_item.joint_pos_4;
                            if (JointCount > 5) r_joint[5 % JointCount] <= r_item.joint_pos_5;
                            if (JointCount > 6) r_joint[6 % JointCount] <= r_item.joint_pos_6;
                            r_jseen <= 1'b1;
                        end
                        ActForce: begin
                            // the force itself was captured in IDLE so the RAM
                            // write this cycle already sees it
                            r_fseen <= 1'b1;
                            if (r_rec && r_jseen && r_count < CountW'(TableDepth)) begin
                                r_count <= r_count + 1'b1;
                            end
                        end
                        ActCheck: begin
                            if (!chk_ok && r_stop) r_stop <= 1'b0;
                        end
                        ActStart: begin
                            r_count <= '0;
                            r_rec <= 1'b1;
                            r_loaded <= 1'b0;
                        end
                        ActFinish: begin
                            r_rec <= 1'b0;
                            if (r_count != 0) r_loaded <= 1'b1;
                        end
                        default: ;
                    endcase
                end
                S_RD: begin
                    r_coord <= '0;
                    r_dist <= '0;
                end
                S_ACC: begin
                    if (r_coord == 4'(JointCount - 1)) begin
                        if (!r_have || (r_dist + 36'(sq)) < r_best) begin
                            r_best <= r_dist + 36'(sq);
                            r_best_idx <= r_idx;
                            r_have <= 1'b1;
                        end
                        r_walk <= r_walk + 1'b1;
                        r_idx <= r_idx + 1'b1;
                    end else begin
                        r_dist <= r_dist + 36'(sq);
                        r_coord <= r_coord + 1'b1;
                    end
                end
                S_FRD: begin
                    r_coord <= '0;
                    r_dist <= '0;
                end
                S_FACC: begin
                    if (r_coord == 4'd2) begin
                        if (facc_sum > 36'(thr_sq)) begin
                            if (!r_stop) r_stop <= 1'b1;
                        end else if (r_stop) begin
                            r_stop <= 1'b0;
                        end
                    end else begin
                        r_dist <= facc_sum;
                        r_coord <= r_coord + 1'b1;
                    end
                end
                default: ;
            endcase
            // capture force in IDLE so the table write in EXEC stores it
            if (r_state == S_IDLE && in_ch.valid && in_ch.payload.action == ActForce) begin
                r_force[0] <= in_ch.payload.force_x;
                r_force[1] <= in_ch.payload.force_y;
                r_force[2] <= in_ch.payload.force_z;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (in_ch.valid) n_state = S_EXEC;
            S_EXEC: begin
                if (r_item.action == ActCheck && chk_ok) n_state = S_RD;
                else n_state = S_OUT;
            end
            S_RD: n_state = S_ACC;
            S_ACC: begin
                if (r_coord == 4'(JointCount - 1)) begin
                    n_state = (r_walk + 1'b1 == r_count) ? S_FRD : S_RD;
                end
            end
            S_FRD: n_state = S_FACC;
            S_FACC: if (r_coord == 4'd2) n_state = S_OUT;
            S_OUT: if (out_ch.ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CountW'(TableDepth)) else $error("count over depth");
    a_stop_restore: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid |-> !(r_out.stop_request && r_out.restored))
        else $error("stop and restore together");
    a_unsafe_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_ch.valid && !r_out.safe) |-> r_item.action == ActCheck)
        else $error("unsafe on non-check");
`endif
endmodule

### tb/nearest_baseline_force_monitor_tb.sv
`timescale 1ns / 1ps
module nearest_baseline_force_monitor_tb;
    import nbfm_pkg::*;

    localparam int WatchLimit = 60000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [14:0] cfg_wdata = '0;

    nbfm_in_if  in_ch ();
    nbfm_out_if out_ch ();

    nearest_baseline_force_monitor dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .in_ch    (in_ch.sink),
        .out_ch   (out_ch.source)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Predictor state: a mirror of the monitor's registers and baseline table.
    typedef struct {
        logic signed [15:0] q[JointCount];
        logic signed [15:0] f[3];
    } t_baseline;

    logic [14:0]        mon_threshold;
    logic signed [15:0] mon_joints[JointCount];
    logic signed [15:0] mon_force[3];
    bit                 mon_joints_seen, mon_force_seen, mon_recording, mon_loaded;
    bit                 mon_stop_latched;
    int unsigned        mon_count;
    t_baseline          mon_table[TableDepth];

    t_out_item pending_results[$];
    int        n_errors = 0;
    int        n_sent = 0, n_checks_hit = 0, n_stops = 0;
    int        in_idle_pct = 0, out_stall_pct = 0;
    int        idle_cycles = 0;

    function automatic logic [33:0] square_diff(logic signed [15:0] a, logic signed [15:0] b);
        logic signed [17:0] d;
        logic [16:0]        m;
        d = 18'(a) - 18'(b);
        m = d[17] ? 17'(-d) : 17'(d);
        return 34'(m) * 34'(m);
    endfunction

    function automatic void monitor_reset();
        mon_threshold = ThresholdReset;
        foreach (mon_joints[j]) mon_joints[j] = '0;
        foreach (mon_force[j]) mon_force[j] = '0;
        mon_joints_seen = 0;
        mon_force_seen = 0;
        mon_recording = 0;
        mon_loaded = 0;
        mon_count = 0;
        mon_stop_latched = 0;
    endfunction

    // Compute the result that one transaction causes and advance the mirror.
    function automatic t_out_item monitor_step(t_in_item it);
        t_out_item r;
        logic [35:0] jdist, best;
        logic [33:0] thr_sq;
        int          idx;
        r = '0;
        r.safe = 1'b1;
        case (it.action)
            ActJoint: begin
                mon_joints[0] = it.joint_pos_0; mon_joints[1] = it.joint_pos_1;
                mon_joints[2] = it.joint_pos_2; mon_joints[3] = it.joint_pos_3;
                mon_joints[4] = it.joint_pos_4; mon_joints[5] = it.joint_pos_5;
                mon_joints[6] = it.joint_pos_6;
                mon_joints_seen = 1;
            end
            ActForce: begin
                mon_force[0] = it.force_x;
                mon_force[1] = it.force_y;
                mon_force[2] = it.force_z;
                mon_force_seen = 1;
                if (mon_recording && mon_joints_seen) begin
                    if (mon_count < TableDepth) begin
                        mon_table[mon_count].q = mon_joints;
                        mon_table[mon_count].f = mon_force;
                        mon_count++;
                    end else begin
                        r.status = StatFull;
                    end
                end
            end
            ActCheck: begin
                if (mon_loaded && mon_force_seen && mon_joints_seen && mon_count > 0) begin
                    idx = 0;
                    best = '1;
                    for (int i = 0; i < mon_count; i++) begin
                        jdist = '0;
                        for (int j = 0; j < JointCount; j++)
                            jdist += 36'(square_diff(mon_joints[j], mon_table[i].q[j]));
                        // strict compare keeps the lowest index on a tie
                        if (i == 0 || jdist < best) begin
                            best = jdist;
                            idx = i;
                        end
                    end
                    for (int j = 0; j < 3; j++)
                        r.delta_square += square_diff(mon_force[j], mon_table[idx].f[j]);
                    r.nearest_index = 8'(idx);
                    thr_sq = 34'(mon_threshold) * 34'(mon_threshold);
                    r.safe = (r.delta_square > thr_sq) ? 1'b0 : 1'b1;
                    n_checks_hit++;
                end
                if (!r.safe && !mon_stop_latched) begin
                    r.stop_request = 1'b1;
                    mon_stop_latched = 1;
                    n_stops++;
                end else if (r.safe && mon_stop_latched) begin
                    r.restored = 1'b1;
                    mon_stop_latched = 0;
                end
            end
            ActStart: begin
                mon_count = 0;
                mon_recording = 1;
                mon_loaded = 0;
            end
            ActFinish: begin
                mon_recording = 0;
                if (mon_count == 0) r.status = StatEmpty;
                else mon_loaded = 1;
            end
            default: ;
        endcase
        r.sample_count = 9'(mon_count);
        r.recording = mon_recording;
        return r;
    endfunction

    // Drive one transaction, holding valid until the handshake completes.
    // Valid stays high afterwards; the next transaction takes it over, or drain() drops it.
    task automatic send_item(t_in_item it);
        while ($urandom_range(99) < in_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.payload <= it;
        pending_results = {pending_results, monitor_step(it)};
        n_sent++;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_threshold(logic [14:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        mon_threshold = v;
    endtask

    function automatic t_in_item make_item(logic [2:0] act, logic [15:0] fill);
        t_in_item it;
        it = '0;
        it.action = act;
        {it.joint_pos_0, it.joint_pos_1, it.joint_pos_2, it.joint_pos_3, it.joint_pos_4,
         it.joint_pos_5, it.joint_pos_6, it.force_x, it.force_y, it.force_z} = {10{fill}};
        return it;
    endfunction

    function automatic t_in_item rand_item(logic [2:0] act, bit near_zero);
        t_in_item it;
        it = '0;
        it.action = act;
        if (near_zero) begin
            it.joint_pos_0 = 16'($urandom_range(64)) - 16'sd32;
            it.joint_pos_1 = 16'($urandom_range(64)) - 16'sd32;
            it.joint_pos_2 = 16'($urandom_range(64)) - 16'sd32;
            it.joint_pos_3 = 16'($urandom_range(64)) - 16'sd32;
            it.joint_pos_4 = 16'($urandom_range(64)) - 16'sd32;
            it.joint_pos_5 = 16'($urandom_range(64)) - 16'sd32;
            it.joint_pos_6 = 16'($urandom_range(64)) - 16'sd32;
            it.force_x = 16'($urandom_range(2000)) - 16'sd1000;
            it.force_y = 16'($urandom_range(2000)) - 16'sd1000;
            it.force_z = 16'($urandom_range(2000)) - 16'sd1000;
        end else begin
            {it.joint_pos_0, it.joint_pos_1, it.joint_pos_2, it.joint_pos_3} =
                {$urandom, $urandom};
            {it.joint_pos_4, it.joint_pos_5, it.joint_pos_6} = 48'({$urandom, $urandom});
            {it.force_x, it.force_y, it.force_z} = 48'({$urandom, $urandom});
        end
        return it;
    endfunction

    // Directed table. has_exp marks rows whose result is plain to read off.
    typedef struct {
        t_in_item  item;
        bit        has_exp;
        t_out_item exp_result;
    } t_directed_row;

    t_directed_row directed[$];

    function automatic t_out_item plain_result(logic [1:0] st, logic [8:0] cnt, logic rec);
        t_out_item r;
        r = '0;
        r.status = st;
        r.safe = 1'b1;
        r.sample_count = cnt;
        r.recording = rec;
        return r;
    endfunction

    function automatic void add_row(t_in_item it, bit has_exp, t_out_item e);
        t_directed_row row;
        row.item = it;
        row.has_exp = has_exp;
        row.exp_result = e;
        directed = {directed, row};
    endfunction

    function automatic void build_directed();
        t_out_item none;
        none = '0;
        // check with nothing loaded, finish on empty table, force before joints, undefined actions
        add_row(make_item(ActCheck, 16'h0000), 1, plain_result(StatOk, 0, 0));
        add_row(make_item(ActFinish, 16'h0000), 1, plain_result(StatEmpty, 0, 0));
        add_row(make_item(ActStart, 16'h0000), 1, plain_result(StatOk, 0, 1));
        add_row(make_item(ActForce, 16'h7FFF), 1, plain_result(StatOk, 0, 1));
        add_row(make_item(3'd5, 16'hFFFF), 1, plain_result(StatOk, 0, 1));
        add_row(make_item(3'd7, 16'h5555), 1, plain_result(StatOk, 0, 1));
        // record extremes: joints at the rails, forces at the rails
        add_row(make_item(ActJoint, 16'h8000), 1, plain_result(StatOk, 0, 1));
        add_row(make_item(ActForce, 16'h8000), 1, plain_result(StatOk, 1, 1));
        add_row(make_item(ActJoint, 16'h7FFF), 1, plain_result(StatOk, 1, 1));
        add_row(make_item(ActForce, 16'h7FFF), 1, plain_result(StatOk, 2, 1));
        add_row(make_item(ActJoint, 16'h8000), 1, plain_result(StatOk, 2, 1));
        add_row(make_item(ActForce, 16'h7FFF), 1, plain_result(StatOk, 3, 1));
        add_row(make_item(ActFinish, 16'h0000), 1, plain_result(StatOk, 3, 0));
        // worst-case deviation on a tie back to entry zero, then restore, then a deviation to entry one
        add_row(make_item(ActJoint, 16'h8000), 0, none);
        add_row(make_item(ActForce, 16'h7FFF), 0, none);
        add_row(make_item(ActCheck, 16'h0000), 0, none);
        add_row(make_item(ActCheck, 16'h0000), 0, none);
        add_row(make_item(ActForce, 16'h8000), 0, none);
        add_row(make_item(ActCheck, 16'h0000), 0, none);
        add_row(make_item(ActJoint, 16'h0000), 0, none);
        add_row(make_item(ActCheck, 16'h0000), 0, none);
        add_row(make_item(ActFinish, 16'h0000), 1, plain_result(StatOk, 3, 0));
    endfunction

    // Receiver: stall at random and compare each transaction field by field.
    always @(posedge i_clk) begin
        t_out_item got, want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                got = out_ch.payload;
                if (pending_results.size() == 0) begin
                    $error("result with nothing expected: %p", got);
                    n_errors++;
                end else begin
                    want = pending_results.pop_front();
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        n_errors++;
                    end
                    if (got.safe !== want.safe) begin
                        $error("safe: expected %0d, got %0d", want.safe, got.safe);
                        n_errors++;
                    end
                    if (got.stop_request !== want.stop_request) begin
                        $error("stop_request: expected %0d, got %0d",
                               want.stop_request, got.stop_request);
                        n_errors++;
                    end
                    if (got.restored !== want.restored) begin
                        $error("restored: expected %0d, got %0d", want.restored, got.restored);
                        n_errors++;
                    end
                    if (got.nearest_index !== want.nearest_index) begin
                        $error("nearest_index: expected %0d, got %0d",
                               want.nearest_index, got.nearest_index);
                        n_errors++;
                    end
                    if (got.delta_square !== want.delta_square) begin
                        $error("delta_square: expected %0d, got %0d",
                               want.delta_square, got.delta_square);
                        n_errors++;
                    end
                    if (got.sample_count !== want.sample_count) begin
                        $error("sample_count: expected %0d, got %0d",
                               want.sample_count, got.sample_count);
                        n_errors++;
                    end
                    if (got.recording !== want.recording) begin
                        $error("recording: expected %0d, got %0d", want.recording, got.recording);
                        n_errors++;
                    end
                end
            end
            out_ch.ready <= ($urandom_range(99) >= out_stall_pct);
        end
    end

    // Watchdog: count cycles with no transaction on either side.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchLimit) begin
            $display("[nearest_baseline_force_monitor] ERROR");
            $finish;
        end
    end

    // One recording session with random content, then a mixed burst of joints, forces, random actions and checks.
    task automatic run_session(int n_samples, int n_checks);
        bit tight;
        tight = 1'($urandom_range(1));
        send_item(rand_item(ActStart, tight));
        for (int s = 0; s < n_samples; s++) begin
            if ($urandom_range(3) != 0) send_item(rand_item(ActJoint, tight));
            send_item(rand_item(ActForce, tight));
        end
        send_item(rand_item(ActFinish, tight));
        for (int c = 0; c < n_checks; c++) begin
            case ($urandom_range(9))
                0, 1, 2: send_item(rand_item(ActJoint, tight));
                3, 4:    send_item(rand_item(ActForce, tight));
                5:       send_item(rand_item(3'($urandom_range(7)), 1'($urandom_range(1))));
                default: send_item(rand_item(ActCheck, tight));
            endcase
        end
    endtask

    initial begin
        int phase_idle[4]  = '{0, 85, 0, 30};
        int phase_stall[4] = '{0, 0, 85, 30};
        logic [14:0] thresholds[4] = '{15'd0, 15'h7FFF, 15'd640, 15'd2000};
        in_ch.valid   = 1'b0;
        in_ch.payload = '0;
        monitor_reset();
        build_directed();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows at reset threshold, both sides idle-free
        foreach (directed[k]) begin
            send_item(directed[k].item);
            if (directed[k].has_exp && pending_results[$] !== directed[k].exp_result) begin
                $error("directed row %0d: table expected %p, predictor %p",
                       k, directed[k].exp_result, pending_results[$]);
                n_errors++;
            end
        end
        drain();

        // fill the table to the brim once to hit the dropped-sample path
        send_item(rand_item(ActStart, 1));
        send_item(rand_item(ActJoint, 1));
        repeat (TableDepth + 2) send_item(rand_item(ActForce, 1));
        send_item(rand_item(ActFinish, 1));
        send_item(rand_item(ActCheck, 1));
        send_item(rand_item(ActCheck, 0));
        drain();

        // random phases: vary threshold and handshake pressure
        for (int p = 0; p < 4; p++) begin
            write_threshold(thresholds[p]);
            in_idle_pct   = phase_idle[p];
            out_stall_pct = phase_stall[p];
            for (int s = 0; s < 10; s++) begin
                // small tables keep check ticks cheap
                run_session($urandom_range(1, 12), $urandom_range(15, 30));
            end
            drain();
        end
        write_threshold(15'($urandom));
        in_idle_pct = 0;
        out_stall_pct = 0;
        run_session(6, 25);
        drain();

        $display("Sent %0d transactions; %0d applicable checks, %0d stop requests.",
                 n_sent, n_checks_hit, n_stops);
        $display("Covered empty finish, full-table drop, idle/stall phases, four thresholds.");
        if (n_errors == 0 && pending_results.size() == 0)
            $display("[nearest_baseline_force_monitor] OK");
        else
            $display("[nearest_baseline_force_monitor] ERROR");
        $finish;
    end
endmodule

### files.f
src/nbfm_pkg.sv
src/nbfm_if.sv
src/nbfm_ram.sv
src/nearest_baseline_force_monitor.sv
tb/nearest_baseline_force_monitor_tb.sv
